>>> hw/rtl/snc_pkg.sv
// Shared types and constants of the SPI NAND command sequencer.
package snc_pkg;

  localparam int unsigned PAGE_BYTES  = 2048;
  localparam int unsigned BLOCK_BYTES = 131072;
  localparam int unsigned CHIP_BYTES  = 134217728;
  localparam int unsigned PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int unsigned CHUNK_W     = 12;
  localparam int unsigned FIDX_W      = 12;
  localparam int unsigned OQ_DEPTH    = 4;

  localparam logic CFG_POLL_LIMIT = 1'b0;
  localparam logic CFG_FAIL_MASK  = 1'b1;

  localparam logic [7:0] OPC_PAGE_READ = 8'h13;
  localparam logic [7:0] OPC_READ_DATA = 8'h03;
  localparam logic [7:0] OPC_PROG_LOAD = 8'h84;
  localparam logic [7:0] OPC_PROG_EXEC = 8'h10;
  localparam logic [7:0] OPC_ERASE     = 8'hD8;
  localparam logic [7:0] OPC_WREN      = 8'h06;
  localparam logic [7:0] OPC_WRDI      = 8'h04;
  localparam logic [7:0] OPC_GET_FEAT  = 8'h0F;
  localparam logic [7:0] REG_STATUS    = 8'hC0;
  localparam logic [7:0] DUMMY_BYTE    = 8'hFF;

  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_ERASE = 3'd2,
    CMD_WDATA = 3'd3,
    CMD_RESP  = 3'd4,
    CMD_TICK  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_RDATA = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_PFAIL   = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] address;
    logic [27:0] length;
    logic [15:0] block_count;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       fend;
    status_t    status;
    logic       last;
  } res_t;

endpackage

>>> hw/rtl/snc_if.sv
// Input and result channel interfaces of the sequencer.
interface snc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] address;
  logic [27:0] length;
  logic [15:0] block_count;
  logic [7:0]  data_byte;

  modport source(output valid, req_type, address, length, block_count, data_byte,
                 input ready);
  modport sink(input valid, req_type, address, length, block_count, data_byte,
               output ready);
endinterface

interface snc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       frame_end;
  logic [1:0] done_status;
  logic       last_of_run;

  modport source(output valid, out_kind, out_byte, frame_end, done_status, last_of_run,
                 input ready);
  modport sink(input valid, out_kind, out_byte, frame_end, done_status, last_of_run,
               output ready);
endinterface

>>> hw/rtl/snc_front.sv
// Front end: accepts input words, decodes the request type, two-entry queue.
module snc_front import snc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  snc_in_if.sink in_ch,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);

  item_t      mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  // codes 6 and 7 never do anything, so they are dropped here
  assign push    = in_ch.valid && in_ch.ready && (in_ch.req_type <= 3'd5);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (q_pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= '{cmd: cmd_t'(in_ch.req_type), address: in_ch.address,
                         length: in_ch.length, block_count: in_ch.block_count,
                         data_byte: in_ch.data_byte};
    end
  end

endmodule

>>> hw/rtl/snc_back.sv
// Back end: command sequencer that turns queued words into link and host results.
module snc_back import snc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_wdata,
  input  logic            q_valid,
  input  item_t           q_item,
  output logic            q_pop,
  input  logic            oq_room,
  output logic [1:0]      res_n,
  output res_t [1:0]      res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_RD_PAGE, PH_POLL, PH_POLL_WAIT, PH_RD_DATA, PH_WREN,
    PH_LOAD, PH_LOAD_WAIT, PH_EXEC, PH_STAT, PH_WRDI, PH_ERASE
  } phase_t;

  typedef enum logic [1:0] {OP_IDLE, OP_READ, OP_WRITE, OP_ERASE} op_t;

  function automatic logic [FIDX_W-1:0] frame_len(phase_t p, logic [CHUNK_W-1:0] c);
    case (p)
      PH_RD_PAGE, PH_EXEC, PH_ERASE: frame_len = FIDX_W'(4);
      PH_POLL, PH_STAT:              frame_len = FIDX_W'(3);
      PH_RD_DATA:                    frame_len = FIDX_W'(4) + FIDX_W'(c);
      PH_LOAD:                       frame_len = FIDX_W'(3) + FIDX_W'(c);
      default:                       frame_len = FIDX_W'(1);
    endcase
  endfunction

  function automatic logic [7:0] first_byte(phase_t p);
    case (p)
      PH_RD_PAGE:       first_byte = OPC_PAGE_READ;
      PH_POLL, PH_STAT: first_byte = OPC_GET_FEAT;
      PH_RD_DATA:       first_byte = OPC_READ_DATA;
      PH_LOAD:          first_byte = OPC_PROG_LOAD;
      PH_EXEC:          first_byte = OPC_PROG_EXEC;
      PH_ERASE:         first_byte = OPC_ERASE;
      PH_WREN:          first_byte = OPC_WREN;
      PH_WRDI:          first_byte = OPC_WRDI;
      default:          first_byte = DUMMY_BYTE;
    endcase
  endfunction

  // byte at a frame position of one or more
  function automatic logic [7:0] later_byte(phase_t p, logic [FIDX_W-1:0] idx,
                                            logic [31:0] addr);
    logic [15:0] pa;
    logic [15:0] ca;
    pa = 16'(addr >> PAGE_SHIFT);
    ca = 16'(addr[PAGE_SHIFT-1:0]);
    case (p)
      PH_RD_PAGE: later_byte = (idx == FIDX_W'(1)) ? DUMMY_BYTE :
                               (idx == FIDX_W'(2)) ? pa[15:8] : pa[7:0];
      PH_POLL, PH_STAT: later_byte = (idx == FIDX_W'(1)) ? REG_STATUS : DUMMY_BYTE;
      PH_RD_DATA: later_byte = (idx == FIDX_W'(1)) ? ca[15:8] :
                               (idx == FIDX_W'(2)) ? ca[7:0] : DUMMY_BYTE;
      PH_LOAD:    later_byte = (idx == FIDX_W'(1)) ? ca[15:8] : ca[7:0];
      // the page index has 16 bits, so its top address byte is zero
      PH_EXEC, PH_ERASE: later_byte = (idx == FIDX_W'(1)) ? 8'h00 :
                                      (idx == FIDX_W'(2)) ? pa[15:8] : pa[7:0];
      default:    later_byte = DUMMY_BYTE;
    endcase
  endfunction

  function automatic res_t mk(kind_t k, logic [7:0] b, logic fe, status_t s);
    mk = '{kind: k, data: b, fend: fe, status: s, last: 1'b0};
  endfunction

  logic [15:0]        poll_limit_r;
  logic [7:0]         fail_mask_r;
  op_t                op_r, op_nxt;
  phase_t             ph_r, ph_nxt;
  logic [31:0]        cur_r, cur_nxt, end_r, end_nxt;
  logic [15:0]        blk_r, blk_nxt, polls_r, polls_nxt;
  logic [FIDX_W-1:0]  fidx_r, fidx_nxt;
  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;

  logic [CHUNK_W-1:0] room_a, chunk_a, chunk_c;
  logic [32:0]        end_a;
  logic               bad_a;
  logic [31:0]        sum_c, rem_c, cur_blk;
  logic               more_c;
  logic [15:0]        blk_dec, polls_inc;
  logic [FIDX_W-1:0]  flen, flen_load, fidx_inc, fidx_inc2;
  logic               do_start, do_finish;
  phase_t             start_ph;
  status_t            fin_st;
  logic [1:0]         nres;
  res_t [1:0]         r;
  item_t              it;

  assign q_pop = q_valid && oq_room;
  assign it    = q_item;

  always_comb begin
    // new access
    room_a  = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(it.address[PAGE_SHIFT-1:0]);
    chunk_a = (28'(room_a) < it.length) ? room_a : it.length[CHUNK_W-1:0];
    end_a   = {1'b0, it.address} + {5'b0, it.length};
    bad_a   = (it.address >= 32'(CHIP_BYTES)) || (end_a > 33'(CHIP_BYTES));
    // next page of a transfer starts page aligned
    sum_c   = cur_r + 32'(chunk_r);
    more_c  = sum_c < end_r;
    rem_c   = end_r - sum_c;
    chunk_c = (rem_c < 32'(PAGE_BYTES)) ? rem_c[CHUNK_W-1:0] : CHUNK_W'(PAGE_BYTES);
    cur_blk = cur_r + 32'(BLOCK_BYTES);
    blk_dec = (blk_r != 16'd0) ? blk_r - 16'd1 : 16'd0;
    polls_inc = (polls_r != 16'hFFFF) ? polls_r + 16'd1 : polls_r;
    flen      = frame_len(ph_r, chunk_r);
    flen_load = frame_len(PH_LOAD, chunk_r);
    fidx_inc  = fidx_r + FIDX_W'(1);
    fidx_inc2 = fidx_r + FIDX_W'(2);

    op_nxt = op_r; ph_nxt = ph_r; cur_nxt = cur_r; end_nxt = end_r; blk_nxt = blk_r;
    polls_nxt = polls_r; fidx_nxt = fidx_r; chunk_nxt = chunk_r;
    do_start = 1'b0; do_finish = 1'b0; start_ph = PH_IDLE; fin_st = ST_OK;
    nres = 2'd0;
    r = '0;

    case (it.cmd)
      CMD_READ, CMD_WRITE: begin
        if (ph_r == PH_IDLE) begin
          op_nxt = (it.cmd == CMD_READ) ? OP_READ : OP_WRITE;
          if (bad_a) begin
            do_finish = 1'b1; fin_st = ST_RANGE;
          end else begin
            cur_nxt = it.address;
            end_nxt = end_a[31:0];
            if (it.length == 28'd0) begin
              do_finish = 1'b1; fin_st = ST_OK;
            end else begin
              chunk_nxt = chunk_a;
              do_start  = 1'b1;
              start_ph  = (it.cmd == CMD_READ) ? PH_RD_PAGE : PH_WREN;
            end
          end
        end
      end
      CMD_ERASE: begin
        if (ph_r == PH_IDLE) begin
          op_nxt  = OP_ERASE;
          cur_nxt = it.address;
          blk_nxt = it.block_count;
          if (it.block_count == 16'd0) begin
            do_finish = 1'b1; fin_st = ST_OK;
          end else if (it.address >= 32'(CHIP_BYTES)) begin
            do_finish = 1'b1; fin_st = ST_RANGE;
          end else begin
            do_start = 1'b1; start_ph = PH_WREN;
          end
        end
      end
      CMD_WDATA: begin
        if (ph_r == PH_LOAD_WAIT) begin
          ph_nxt = PH_LOAD;
          r[0]   = mk(KIND_SEND, it.data_byte, fidx_inc >= flen_load, ST_OK);
          nres   = 2'd1;
        end
      end
      CMD_RESP: begin
        if (ph_r != PH_IDLE && ph_r != PH_POLL_WAIT && ph_r != PH_LOAD_WAIT) begin
          if (ph_r == PH_RD_DATA && fidx_r >= FIDX_W'(4)) begin
            r[0] = mk(KIND_RDATA, it.data_byte, 1'b0, ST_OK);
            nres = 2'd1;
          end
          if (fidx_inc >= flen) begin
            // end of frame
            case (ph_r)
              PH_RD_PAGE, PH_EXEC, PH_ERASE: begin
                polls_nxt = 16'd0;
                do_start = 1'b1; start_ph = PH_POLL;
              end
              PH_POLL: begin
                if (!it.data_byte[0]) begin
                  case (op_r)
                    OP_READ:  begin do_start = 1'b1; start_ph = PH_RD_DATA; end
                    OP_WRITE: begin do_start = 1'b1; start_ph = PH_STAT; end
                    OP_ERASE: begin do_start = 1'b1; start_ph = PH_WRDI; end
                    default:  begin do_finish = 1'b1; fin_st = ST_OK; end
                  endcase
                end else begin
                  polls_nxt = polls_inc;
                  if (polls_inc >= poll_limit_r) begin
                    do_finish = 1'b1; fin_st = ST_TIMEOUT;
                  end else begin
                    ph_nxt = PH_POLL_WAIT;
                  end
                end
              end
              PH_RD_DATA: begin
                cur_nxt = sum_c;
                if (more_c) begin
                  chunk_nxt = chunk_c;
                  do_start = 1'b1; start_ph = PH_RD_PAGE;
                end else begin
                  do_finish = 1'b1; fin_st = ST_OK;
                end
              end
              PH_WREN: begin
                do_start = 1'b1;
                start_ph = (op_r == OP_WRITE) ? PH_LOAD : PH_ERASE;
              end
              PH_LOAD: begin
                do_start = 1'b1; start_ph = PH_EXEC;
              end
              PH_STAT: begin
                if ((it.data_byte & fail_mask_r) != 8'd0) begin
                  do_finish = 1'b1; fin_st = ST_PFAIL;
                end else begin
                  do_start = 1'b1; start_ph = PH_WRDI;
                end
              end
              PH_WRDI: begin
                if (op_r == OP_WRITE) begin
                  cur_nxt = sum_c;
                  if (more_c) begin
                    chunk_nxt = chunk_c;
                    do_start = 1'b1; start_ph = PH_WREN;
                  end else begin
                    do_finish = 1'b1; fin_st = ST_OK;
                  end
                end else begin
                  blk_nxt = blk_dec;
                  cur_nxt = cur_blk;
                  if (blk_dec == 16'd0) begin
                    do_finish = 1'b1; fin_st = ST_OK;
                  end else if (cur_blk >= 32'(CHIP_BYTES)) begin
                    do_finish = 1'b1; fin_st = ST_RANGE;
                  end else begin
                    do_start = 1'b1; start_ph = PH_WREN;
                  end
                end
              end
              default: ;
            endcase
          end else begin
            fidx_nxt = fidx_inc;
            if (ph_r == PH_LOAD && fidx_inc >= FIDX_W'(3)) begin
              ph_nxt = PH_LOAD_WAIT;
            end else begin
              r[nres[0]] = mk(KIND_SEND, later_byte(ph_r, fidx_inc, cur_r),
                              fidx_inc2 >= flen, ST_OK);
              nres = nres + 2'd1;
            end
          end
        end
      end
      CMD_TICK: begin
        if (ph_r == PH_POLL_WAIT) begin
          do_start = 1'b1; start_ph = PH_POLL;
        end
      end
      default: ;
    endcase

    if (do_start) begin
      ph_nxt   = start_ph;
      fidx_nxt = '0;
      r[nres[0]] = mk(KIND_SEND, first_byte(start_ph),
                      (start_ph == PH_WREN) || (start_ph == PH_WRDI), ST_OK);
      nres = nres + 2'd1;
    end
    if (do_finish) begin
      op_nxt = OP_IDLE;
      ph_nxt = PH_IDLE;
      r[nres[0]] = mk(KIND_DONE, 8'h00, 1'b0, fin_st);
      nres = nres + 2'd1;
    end
    if (nres != 2'd0) r[nres[1]].last = 1'b1;
  end

  assign res_n = q_pop ? nres : 2'd0;
  assign res   = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= 16'd500;
      fail_mask_r  <= 8'h0E;
      op_r    <= OP_IDLE;
      ph_r    <= PH_IDLE;
      cur_r   <= '0;
      end_r   <= '0;
      blk_r   <= '0;
      fidx_r  <= '0;
      chunk_r <= '0;
      polls_r <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_POLL_LIMIT) poll_limit_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_FAIL_MASK)  fail_mask_r  <= cfg_wdata[7:0];
      if (q_pop) begin
        op_r    <= op_nxt;
        ph_r    <= ph_nxt;
        cur_r   <= cur_nxt;
        end_r   <= end_nxt;
        blk_r   <= blk_nxt;
        fidx_r  <= fidx_nxt;
        chunk_r <= chunk_nxt;
        polls_r <= polls_nxt;
      end
    end
  end

  a_op_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_IDLE) == (op_r == OP_IDLE))
    else $error("operation and phase disagree on idle");

  a_fidx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r != PH_IDLE && ph_r != PH_POLL_WAIT && ph_r != PH_LOAD_WAIT)
      |-> (fidx_r < frame_len(ph_r, chunk_r)))
    else $error("frame index past end of frame");

  a_chunk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_RD_DATA || ph_r == PH_LOAD)
      |-> (chunk_r != '0 && chunk_r <= CHUNK_W'(PAGE_BYTES)))
    else $error("chunk length out of range");

endmodule

>>> hw/rtl/snc_outq.sv
// Result queue: takes up to two results a cycle, hands out one word a cycle while the sink is ready.
module snc_outq import snc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  wr_n,
  input  res_t [1:0]  wr_res,
  output logic        room,
  snc_out_if.source   out_ch
);

  localparam int unsigned PW = $clog2(OQ_DEPTH);

  res_t          mem_r [OQ_DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [PW:0]   cnt_r;
  logic          pop;
  res_t          head;

  assign room  = (cnt_r <= (PW+1)'(OQ_DEPTH - 2));
  assign pop   = out_ch.valid && out_ch.ready;
  assign head  = mem_r[rptr_r];

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.out_kind    = head.kind;
  assign out_ch.out_byte    = head.data;
  assign out_ch.frame_end   = head.fend;
  assign out_ch.done_status = head.status;
  assign out_ch.last_of_run = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + PW'(wr_n);
      if (pop) rptr_r <= rptr_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(wr_n) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) mem_r[wptr_r] <= wr_res[0];
    if (wr_n == 2'd2) mem_r[wptr_r + PW'(1)] <= wr_res[1];
  end

endmodule

>>> hw/rtl/spi_nand_command_sequencer.sv
// Top level of the SPI NAND command sequencer.
//
//   port      dir   handshake        contents
//   in_ch     in    valid/ready      request, write data, link response or poll tick
//   out_ch    out   valid/ready      link byte with frame end, read data, done status
//   cfg_*     in    cfg_we           index 0 poll limit, index 1 fail mask
//
// One input word per cycle while the front queue has room. A word yields up to
// two results, drained one per cycle while out_ch is ready, from a
// four-entry result queue; the back end takes a word only with two free slots.
// Synchronous active-low reset; no clearing pass. Either side may stall freely.
module spi_nand_command_sequencer import snc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  snc_in_if.sink      in_ch,
  snc_out_if.source   out_ch
);

  logic       q_valid, q_pop, oq_room;
  item_t      q_item;
  logic [1:0] res_n;
  res_t [1:0] res;

  snc_front u_front (
    .clk, .rst_n, .in_ch,
    .q_valid, .q_item, .q_pop
  );

  snc_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .q_valid, .q_item, .q_pop, .oq_room, .res_n, .res
  );

  snc_outq u_outq (
    .clk, .rst_n, .wr_n(res_n), .wr_res(res), .room(oq_room), .out_ch
  );

endmodule
